// ===== design/tsps_pkg.sv =====
// Package for the temperature sensor poll sequencer.
// Holds widths, reset values, register indexes, bus command codes and state types.
// No dependencies.
package tsps_pkg;

  // Field and register widths
  localparam int unsigned MS_W        = 32;
  localparam int unsigned DLY_W       = 16;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned SUM_W       = 19;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned TGT_W       = 3;
  localparam int unsigned QIDX_W      = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Default sensor capacity
  localparam int unsigned MAX_SENSORS_DEF = 8;

  // Register reset values
  localparam logic [DLY_W-1:0] CONV_MS_RST    = 16'd750;
  localparam logic [DLY_W-1:0] TIMEOUT_MS_RST = 16'd25;
  localparam logic [DLY_W-1:0] RETRY_MS_RST   = 16'd1000;
  localparam logic [VAL_W-1:0] MARKER_RST     = 16'h8000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONV_MS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER       = 3'd4;

  // Bus driver commands
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_READ  = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_t;

  // Acquisition phase
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_XMIT  = 2'd1,
    PH_CONV  = 2'd2,
    PH_READ  = 2'd3
  } phase_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FILL_STG,
    ST_FILL_PUB,
    ST_COPY,
    ST_SUM,
    ST_QUERY,
    ST_DONE
  } state_t;

endpackage

// ===== design/temp_sensor_poll_sequencer.sv =====
// Poll sequencer for continuous acquisition from a group of 1-Wire temperature sensors.
// Depends on tsps_pkg. Holds the phase logic, staged and published reading memories
// and the serial sweep sequencer.
//
// Usage:
//   One input beat is one poll (time, bus flags, last reading, query index). Each poll
//   gives exactly one result beat: bus command and target, publish/fail flags, the
//   queried published reading, and the sum and count of valid published readings.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while the block is idle.
// Sequencing:
//   A poll is decided in the decide state, then a small sequencer sweeps the reading
//   memories one entry per cycle: optional staging fill, publish copy or failure
//   fill, the valid sum, then the query read. No new poll is taken until the result
//   is loaded; in_ready returns in the cycle after that. The single read port of
//   each memory and the one accumulator keep the sweep serial.
// Reset: phase returns to start conversion, timers and position clear, every
//   published reading reads as 16'h8000, registers take their defaults. No clearing
//   pass is needed.
// Stall: a finished result waits in the output register while out_ready is low;
//   the next poll is accepted meanwhile and holds in its last state until the slot frees.
module temp_sensor_poll_sequencer #(
  parameter int unsigned MAX_SENSORS = tsps_pkg::MAX_SENSORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [tsps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Poll input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tsps_pkg::MS_W-1:0]           in_now_ms,
  input  logic                                in_bus_busy,
  input  logic                                in_bus_error,
  input  logic                                in_command_refused,
  input  logic signed [tsps_pkg::VAL_W-1:0]   in_read_value,
  input  logic [tsps_pkg::QIDX_W-1:0]         in_query_index,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_bus_command,
  output logic [tsps_pkg::TGT_W-1:0]          out_read_target,
  output logic                                out_set_published,
  output logic                                out_cycle_failed,
  output logic signed [tsps_pkg::VAL_W-1:0]   out_query_value,
  output logic signed [tsps_pkg::SUM_W-1:0]   out_valid_sum,
  output logic [tsps_pkg::CNT_W-1:0]          out_valid_count
);
  import tsps_pkg::*;

  localparam int unsigned AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CW = $clog2(MAX_SENSORS + 1);

  // Configuration registers
  logic [CNT_W-1:0]         cfg_count_r;
  logic [DLY_W-1:0]         cfg_conv_r;
  logic [DLY_W-1:0]         cfg_timeout_r;
  logic [DLY_W-1:0]         cfg_retry_r;
  logic [VAL_W-1:0]         cfg_marker_r;

  // Captured poll
  logic [MS_W-1:0]          now_r;
  logic                     busy_r;
  logic                     err_r;
  logic                     refused_r;
  logic [VAL_W-1:0]         rd_r;
  logic [QIDX_W-1:0]        q_r;

  // Sequencer and acquisition state
  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [MS_W-1:0]          start_r, start_nxt;
  logic [DLY_W-1:0]         delay_r, delay_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;

  // Decision of the current poll
  cmd_t                     cmd_r, cmd_nxt;
  logic [TGT_W-1:0]         target_r, target_nxt;
  logic                     pubf_r, pubf_nxt;
  logic                     fail_r, fail_nxt;
  logic                     fill_stg_r, fill_stg_nxt;
  logic                     copy_r, copy_nxt;

  // Sweep counter, read pipeline and accumulator
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            idx_inc;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            rd_idx_r, rd_idx_nxt;
  logic signed [SUM_W-1:0]  acc_sum_r, acc_sum_nxt;
  logic [CNT_W-1:0]         acc_cnt_r, acc_cnt_nxt;

  // Memories
  logic [VAL_W-1:0]         stg_mem [MAX_SENSORS];
  logic [VAL_W-1:0]         pub_mem [MAX_SENSORS];
  logic [MAX_SENSORS-1:0]   pub_vld_r;
  logic [VAL_W-1:0]         stg_rdata_r;
  logic [VAL_W-1:0]         pub_rdata_r;
  logic                     pub_rvld_r;
  logic                     stg_we, stg_re, pub_we, pub_re;
  logic [AW-1:0]            stg_waddr, stg_raddr, pub_waddr, pub_raddr;
  logic [VAL_W-1:0]         stg_wdata, pub_wdata;
  logic signed [VAL_W-1:0]  pub_eff;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  cmd_t                     out_cmd_r;
  logic [TGT_W-1:0]         out_target_r;
  logic                     out_pubf_r;
  logic                     out_fail_r;
  logic [VAL_W-1:0]         out_qv_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_load;

  // Derived values
  logic [CW-1:0]            n_act;
  logic [DLY_W-1:0]         dly_sel;
  logic [MS_W-1:0]          elapsed_ms;
  logic                     elapsed_ok;
  logic [POS_W-1:0]         pos_inc;
  logic                     q_in_range;

  assign n_act = (32'(cfg_count_r) > 32'(MAX_SENSORS)) ? CW'(MAX_SENSORS) : CW'(cfg_count_r);

  // Elapsed-time compare for the current phase
  always_comb begin
    case (phase_r)
      PH_START: dly_sel = delay_r;
      PH_CONV:  dly_sel = cfg_conv_r;
      default:  dly_sel = cfg_timeout_r;
    endcase
  end
  assign elapsed_ms = now_r - start_r;
  assign elapsed_ok = elapsed_ms >= MS_W'(dly_sel);

  assign pos_inc    = pos_r + POS_W'(1);
  assign idx_inc    = idx_r + CW'(1);
  assign q_in_range = 32'(q_r) < 32'(n_act);
  assign pub_eff    = pub_rvld_r ? pub_rdata_r : MARKER_RST;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign in_ready = (state_r == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r   <= '0;
      cfg_conv_r    <= CONV_MS_RST;
      cfg_timeout_r <= TIMEOUT_MS_RST;
      cfg_retry_r   <= RETRY_MS_RST;
      cfg_marker_r  <= MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_COUNT: cfg_count_r   <= cfg_wdata[CNT_W-1:0];
        REG_CONV_MS:      cfg_conv_r    <= cfg_wdata[DLY_W-1:0];
        REG_TIMEOUT_MS:   cfg_timeout_r <= cfg_wdata[DLY_W-1:0];
        REG_RETRY_MS:     cfg_retry_r   <= cfg_wdata[DLY_W-1:0];
        REG_MARKER:       cfg_marker_r  <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Poll capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r     <= in_now_ms;
      busy_r    <= in_bus_busy;
      err_r     <= in_bus_error;
      refused_r <= in_command_refused;
      rd_r      <= in_read_value;
      q_r       <= in_query_index;
    end
  end

  // Sequencer: next state, memory port control, accumulation
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    delay_nxt     = delay_r;
    pos_nxt       = pos_r;
    cmd_nxt       = cmd_r;
    target_nxt    = target_r;
    pubf_nxt      = pubf_r;
    fail_nxt      = fail_r;
    fill_stg_nxt  = fill_stg_r;
    copy_nxt      = copy_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    rd_idx_nxt    = rd_idx_r;
    acc_sum_nxt   = acc_sum_r;
    acc_cnt_nxt   = acc_cnt_r;
    stg_we        = 1'b0;
    stg_waddr     = idx_r[AW-1:0];
    stg_wdata     = cfg_marker_r;
    stg_re        = 1'b0;
    stg_raddr     = idx_r[AW-1:0];
    pub_we        = 1'b0;
    pub_waddr     = idx_r[AW-1:0];
    pub_wdata     = cfg_marker_r;
    pub_re        = 1'b0;
    pub_raddr     = idx_r[AW-1:0];
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end

      // Phase logic of one poll
      ST_DECIDE: begin
        cmd_nxt      = CMD_NONE;
        target_nxt   = '0;
        pubf_nxt     = 1'b0;
        fail_nxt     = 1'b0;
        fill_stg_nxt = 1'b0;
        copy_nxt     = 1'b0;
        idx_nxt      = '0;
        pend_nxt     = 1'b0;
        acc_sum_nxt  = '0;
        acc_cnt_nxt  = '0;
        if (n_act != '0) begin
          case (phase_r)
            PH_START: begin
              if (elapsed_ok) begin
                cmd_nxt = CMD_START;
                if (refused_r) begin
                  fail_nxt = 1'b1;
                end else begin
                  start_nxt = now_r;
                  phase_nxt = PH_XMIT;
                end
              end
            end
            PH_XMIT: begin
              if (busy_r) begin
                if (elapsed_ok) begin
                  cmd_nxt  = CMD_ABORT;
                  fail_nxt = 1'b1;
                end
              end else if (err_r) begin
                fail_nxt = 1'b1;
              end else begin
                start_nxt = now_r;
                phase_nxt = PH_CONV;
              end
            end
            PH_CONV: begin
              if (elapsed_ok) begin
                fill_stg_nxt = 1'b1;
                pos_nxt      = '0;
                cmd_nxt      = CMD_READ;
                if (refused_r) begin
                  fail_nxt = 1'b1;
                end else begin
                  start_nxt = now_r;
                  phase_nxt = PH_READ;
                end
              end
            end
            default: begin
              if (busy_r) begin
                if (elapsed_ok) begin
                  cmd_nxt  = CMD_ABORT;
                  fail_nxt = 1'b1;
                end
              end else if (err_r) begin
                fail_nxt = 1'b1;
              end else begin
                // Stage the finished reading and move on
                if (32'(pos_r) < 32'(MAX_SENSORS)) begin
                  stg_we    = 1'b1;
                  stg_waddr = AW'(pos_r);
                  stg_wdata = rd_r;
                end
                pos_nxt = pos_inc;
                if (32'(pos_inc) >= 32'(n_act)) begin
                  copy_nxt  = 1'b1;
                  pubf_nxt  = 1'b1;
                  phase_nxt = PH_START;
                  start_nxt = now_r;
                  delay_nxt = '0;
                end else begin
                  cmd_nxt    = CMD_READ;
                  target_nxt = pos_inc[TGT_W-1:0];
                  if (refused_r) begin
                    fail_nxt = 1'b1;
                  end else begin
                    start_nxt = now_r;
                  end
                end
              end
            end
          endcase
          // Failure path: restart after the retry pause
          if (fail_nxt) begin
            phase_nxt = PH_START;
            start_nxt = now_r;
            delay_nxt = cfg_retry_r;
          end
        end
        if (fill_stg_nxt) begin
          state_nxt = ST_FILL_STG;
        end else if (fail_nxt) begin
          state_nxt = ST_FILL_PUB;
        end else if (copy_nxt) begin
          state_nxt = ST_COPY;
        end else begin
          state_nxt = ST_SUM;
        end
      end

      // Marker into every staged entry in use
      ST_FILL_STG: begin
        stg_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc == n_act) begin
          idx_nxt   = '0;
          state_nxt = fail_r ? ST_FILL_PUB : ST_SUM;
        end
      end

      // Marker into every published entry in use
      ST_FILL_PUB: begin
        pub_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc == n_act) begin
          idx_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end

      // Staged set to published, one read in flight
      ST_COPY: begin
        if (pend_r) begin
          pub_we    = 1'b1;
          pub_waddr = rd_idx_r;
          pub_wdata = stg_rdata_r;
        end
        if (idx_r < n_act) begin
          stg_re     = 1'b1;
          rd_idx_nxt = idx_r[AW-1:0];
          idx_nxt    = idx_inc;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            idx_nxt   = '0;
            state_nxt = ST_SUM;
          end
        end
      end

      // Sum and count of valid published readings
      ST_SUM: begin
        if (pend_r && (pub_eff != cfg_marker_r)) begin
          acc_sum_nxt = acc_sum_r + SUM_W'(pub_eff);
          acc_cnt_nxt = acc_cnt_r + CNT_W'(1);
        end
        if (idx_r < n_act) begin
          pub_re   = 1'b1;
          idx_nxt  = idx_inc;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            idx_nxt   = '0;
            state_nxt = ST_QUERY;
          end
        end
      end

      ST_QUERY: begin
        pub_re    = 1'b1;
        pub_raddr = AW'(q_r);
        state_nxt = ST_DONE;
      end

      // Wait for a free output slot
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_START;
      start_r     <= '0;
      delay_r     <= '0;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      delay_r     <= delay_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    target_r   <= target_nxt;
    pubf_r     <= pubf_nxt;
    fail_r     <= fail_nxt;
    fill_stg_r <= fill_stg_nxt;
    copy_r     <= copy_nxt;
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    acc_sum_r  <= acc_sum_nxt;
    acc_cnt_r  <= acc_cnt_nxt;
  end

  // Staged readings memory
  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= stg_wdata;
    end
    if (stg_re) begin
      stg_rdata_r <= stg_mem[stg_raddr];
    end
  end

  // Published readings memory
  always_ff @(posedge clk) begin
    if (pub_we) begin
      pub_mem[pub_waddr] <= pub_wdata;
    end
    if (pub_re) begin
      pub_rdata_r <= pub_mem[pub_raddr];
      pub_rvld_r  <= pub_vld_r[pub_raddr];
    end
  end

  // Published entry valid bits; an entry never written reads as the reset marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pub_vld_r <= '0;
    end else if (pub_we) begin
      pub_vld_r[pub_waddr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmd_r    <= cmd_r;
      out_target_r <= target_r;
      out_pubf_r   <= pubf_r;
      out_fail_r   <= fail_r;
      out_qv_r     <= q_in_range ? pub_eff : cfg_marker_r;
      out_sum_r    <= acc_sum_r;
      out_cnt_r    <= acc_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bus_command   = out_cmd_r;
  assign out_read_target   = out_target_r;
  assign out_set_published = out_pubf_r;
  assign out_cycle_failed  = out_fail_r;
  assign out_query_value   = out_qv_r;
  assign out_valid_sum     = out_sum_r;
  assign out_valid_count   = out_cnt_r;

endmodule

// ===== design/tsps_checker.sv =====
// Port-level checks for the temperature sensor poll sequencer.
// Depends on tsps_pkg; bound to temp_sensor_poll_sequencer below.
module tsps_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         out_bus_command,
  input logic [tsps_pkg::TGT_W-1:0]         out_read_target,
  input logic                               out_set_published,
  input logic                               out_cycle_failed,
  input logic signed [tsps_pkg::SUM_W-1:0]  out_valid_sum,
  input logic [tsps_pkg::CNT_W-1:0]         out_valid_count
);
  import tsps_pkg::*;

  // A poll is worked on alone: no new beat right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input beat");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bus_command)
      && $stable(out_valid_sum) && $stable(out_valid_count))
    else $error("stalled result changed");

  // Publish and failure never come together
  a_pub_xor_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_set_published && out_cycle_failed))
    else $error("result both published and failed");

  // After a failure every reading in use holds the marker
  a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_failed |-> out_valid_count == '0 && out_valid_sum == '0)
    else $error("valid readings left after failure");

  // Target is only given with a read request
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bus_command != CMD_READ) |-> out_read_target == '0)
    else $error("read target set without read request");

endmodule

bind temp_sensor_poll_sequencer tsps_checker u_tsps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_bus_command   (out_bus_command),
  .out_read_target   (out_read_target),
  .out_set_published (out_set_published),
  .out_cycle_failed  (out_cycle_failed),
  .out_valid_sum     (out_valid_sum),
  .out_valid_count   (out_valid_count)
);
